// ===== hdl/crts_pkg.sv =====
// Shared widths, codes and types of the credit ready time scheduler.
`timescale 1ns / 1ps
package crts_pkg;

	localparam int FIRST_GROUP_SIZE_DEF = 4;
	localparam int TABLE_DEPTH_DEF      = 16;

	localparam int CREDIT_W = 16;
	localparam int RATE_W   = 8;
	localparam int UNITS_W  = 16;
	localparam int NUM_W    = CREDIT_W + 1;

	typedef enum logic [1:0] {
		ACT_LOAD   = 2'd0,
		ACT_CREDIT = 2'd1,
		ACT_SCHED  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_WRITE   = 2'd0,
		ST_GRANT   = 2'd1,
		ST_OPEN    = 2'd2,
		ST_NOELIG  = 2'd3
	} status_t;

	typedef struct packed {
		logic [CREDIT_W-1:0] credit;
		logic [RATE_W-1:0]   rate;
		logic [CREDIT_W-1:0] ceiling;
		logic                alive;
		logic                stunned;
	} entry_t;

endpackage

// ===== hdl/crts_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
module crts_div #(
	parameter int NW = crts_pkg::NUM_W,
	parameter int DW = crts_pkg::RATE_W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quot
);
	localparam int CW = $clog2(NW + 1);

	logic [CW-1:0] cnt_q;
	logic [NW-1:0] n_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic          ge;

	assign trial = {rem_q, n_q[NW-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(NW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
			n_q   <= {n_q[NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = n_q;

endmodule

// ===== hdl/credit_ready_time_scheduler_unit.sv =====
// Top level of the credit ready time scheduler with its entry table and sequencer.
// A load, an unused code or a refused schedule goes from idle straight to the done state, and a
// credit write passes through a read and a write state first; the next item is taken back in idle.
// A schedule walks the table up to three times: a first pass that runs the shared divider on each
// eligible entry below its ceiling, then a pass for the advance and a pass for the pick.
`timescale 1ns / 1ps
module credit_ready_time_scheduler_unit #(
	parameter int FIRST_GROUP_SIZE = crts_pkg::FIRST_GROUP_SIZE_DEF,
	parameter int TABLE_DEPTH      = crts_pkg::TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [3:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [3:0]  entry_index,
	input  logic [15:0] credit_value,
	input  logic [7:0]  rate_value,
	input  logic [15:0] ceiling_value,
	input  logic        alive_value,
	input  logic        stunned_value,
	input  logic        commit_flag,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [3:0]  granted_index,
	output logic        granted_first_group,
	output logic [15:0] elapsed_units,
	output logic [4:0]  ready_total,
	output logic [15:0] turn_number
);
	import crts_pkg::*;

	localparam int AW   = $clog2(TABLE_DEPTH);
	localparam int RW   = $clog2(TABLE_DEPTH + 1);
	localparam int ROOM = (TABLE_DEPTH > FIRST_GROUP_SIZE) ? TABLE_DEPTH - FIRST_GROUP_SIZE : 0;

	typedef enum logic [11:0] {
		S_IDLE  = 12'b000000000001,
		S_WRD   = 12'b000000000010,
		S_WEV   = 12'b000000000100,
		S_P1RD  = 12'b000000001000,
		S_P1EV  = 12'b000000010000,
		S_P1DIV = 12'b000000100000,
		S_P2RD  = 12'b000001000000,
		S_P2EV  = 12'b000010000000,
		S_P2WR  = 12'b000100000000,
		S_P3RD  = 12'b001000000000,
		S_P3EV  = 12'b010000000000,
		S_DONE  = 12'b100000000000
	} state_t;

	state_t                state_q;
	logic [2:0]            player_q;
	logic [3:0]            npc_q;
	entry_t                mem_q [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] vld_q;
	entry_t                rd_q;
	logic                  rd_vld_q;
	entry_t                cur;
	logic [AW-1:0]         cnt_q;
	logic                  last;
	logic [CREDIT_W-1:0]   wcredit_q;
	logic                  commit_q;
	logic [AW-1:0]         act_idx_q;
	logic                  act_valid_q;
	logic                  closed_q;
	logic [15:0]           turn_q;
	status_t               res_q;
	logic                  found_q;
	logic [UNITS_W-1:0]    best_q;
	logic [RW-1:0]         ready_q;
	logic [23:0]           prod_q;
	logic                  out_valid_q;
	logic [1:0]            status_q;
	logic [3:0]            gidx_q;
	logic                  first_q;
	logic [15:0]           elapsed_q;
	logic [4:0]            readyt_q;
	logic [15:0]           turnn_q;

	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	entry_t                mem_wdata;
	logic                  in_set;
	logic                  elig;
	logic                  rdy_ent;
	logic                  div_start;
	logic                  div_done;
	logic [NUM_W-1:0]      div_num;
	logic [NUM_W-1:0]      div_quot;
	logic [UNITS_W-1:0]    units;
	logic [CREDIT_W+8:0]   sum;
	logic                  idx_ok;
	logic                  accept;

	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign idx_ok = 32'(entry_index) < TABLE_DEPTH;
	assign last = (cnt_q == AW'(TABLE_DEPTH - 1));
	assign cur = rd_vld_q ? rd_q : '0;

	always_comb begin
		int pc;
		int nc;
		int ix;
		pc = (32'(player_q) > FIRST_GROUP_SIZE) ? FIRST_GROUP_SIZE : 32'(player_q);
		nc = (32'(npc_q) > ROOM) ? ROOM : 32'(npc_q);
		ix = 32'(cnt_q);
		in_set = (ix < pc) || (ix >= FIRST_GROUP_SIZE && ix - FIRST_GROUP_SIZE < nc);
	end

	assign elig    = in_set && cur.alive && !cur.stunned && (cur.rate != '0);
	assign rdy_ent = in_set && cur.alive && !cur.stunned && (cur.credit >= cur.ceiling);
	assign div_num = {1'b0, cur.ceiling} - {1'b0, cur.credit} + NUM_W'(cur.rate) - NUM_W'(1);
	assign div_start = (state_q == S_P1EV) && elig && (cur.credit < cur.ceiling);
	assign units = (state_q == S_P1DIV) ? UNITS_W'(div_quot) : '0;
	assign sum = (CREDIT_W+9)'(cur.credit) + (CREDIT_W+9)'(prod_q);

	crts_div #(.NW(NUM_W), .DW(RATE_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (cur.rate),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cnt_q;
		mem_wdata = cur;
		unique case (state_q)
			S_IDLE: begin
				mem_we    = accept && (action == ACT_LOAD) && idx_ok;
				mem_waddr = AW'(entry_index);
				mem_wdata = '{credit: credit_value, rate: rate_value, ceiling: ceiling_value,
					alive: alive_value, stunned: stunned_value};
			end
			S_WEV: begin
				mem_we           = 1'b1;
				mem_wdata.credit = wcredit_q;
			end
			S_P2WR: begin
				mem_we           = 1'b1;
				mem_wdata.credit = (sum > (CREDIT_W+9)'(cur.ceiling)) ? cur.ceiling :
					CREDIT_W'(sum);
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem_q[cnt_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (mem_we) begin
				vld_q[mem_waddr] <= 1'b1;
			end
			rd_vld_q <= vld_q[cnt_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			player_q <= '0;
			npc_q    <= '0;
		end else if (cfg_we) begin
			if (cfg_index == 1'b0) begin
				player_q <= cfg_wdata[2:0];
			end else begin
				npc_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			act_idx_q   <= '0;
			act_valid_q <= 1'b0;
			closed_q    <= 1'b0;
			turn_q      <= '0;
			res_q       <= ST_WRITE;
			found_q     <= 1'b0;
			best_q      <= '0;
			ready_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						priority if (action == ACT_CREDIT && idx_ok) begin
							res_q   <= ST_WRITE;
							cnt_q   <= AW'(entry_index);
							state_q <= S_WRD;
						end else if (action == ACT_SCHED) begin
							cnt_q   <= '0;
							found_q <= 1'b0;
							ready_q <= '0;
							if (act_valid_q && !closed_q) begin
								res_q   <= ST_OPEN;
								state_q <= S_DONE;
							end else begin
								res_q   <= ST_WRITE;
								state_q <= S_P1RD;
							end
						end else begin
							res_q   <= ST_WRITE;
							state_q <= S_DONE;
						end
					end
				end
				S_WRD: begin
					state_q <= S_WEV;
				end
				S_WEV: begin
					if (commit_q) begin
						closed_q <= 1'b1;
						turn_q   <= turn_q + 1'b1;
					end
					state_q <= S_DONE;
				end
				S_P1RD: begin
					state_q <= S_P1EV;
				end
				S_P1EV, S_P1DIV: begin
					if (state_q == S_P1EV && div_start) begin
						state_q <= S_P1DIV;
					end else if (state_q == S_P1DIV && !div_done) begin
						state_q <= S_P1DIV;
					end else begin
						if (elig && (!found_q || units < best_q)) begin
							best_q <= units;
						end
						if (elig) begin
							found_q <= 1'b1;
						end
						if (!last) begin
							cnt_q   <= cnt_q + 1'b1;
							state_q <= S_P1RD;
						end else begin
							cnt_q <= '0;
							priority if (!found_q && !elig) begin
								res_q   <= ST_NOELIG;
								state_q <= S_DONE;
							end else if ((elig && (!found_q || units < best_q)) ?
								(units != '0) : (best_q != '0)) begin
								state_q <= S_P2RD;
							end else begin
								state_q <= S_P3RD;
							end
						end
					end
				end
				S_P2RD: begin
					state_q <= S_P2EV;
				end
				S_P2EV: begin
					if (elig) begin
						state_q <= S_P2WR;
					end else if (!last) begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_P2RD;
					end else begin
						cnt_q   <= '0;
						state_q <= S_P3RD;
					end
				end
				S_P2WR: begin
					if (!last) begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_P2RD;
					end else begin
						cnt_q   <= '0;
						state_q <= S_P3RD;
					end
				end
				S_P3RD: begin
					state_q <= S_P3EV;
				end
				S_P3EV: begin
					if (rdy_ent) begin
						ready_q <= ready_q + 1'b1;
						if (res_q != ST_GRANT) begin
							res_q       <= ST_GRANT;
							act_idx_q   <= cnt_q;
							act_valid_q <= 1'b1;
							closed_q    <= 1'b0;
						end
					end
					if (!last) begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_P3RD;
					end else begin
						if (!rdy_ent && res_q != ST_GRANT) begin
							res_q <= ST_NOELIG;
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			wcredit_q <= credit_value;
			commit_q  <= commit_flag;
		end
		if (state_q == S_P2EV) begin
			prod_q <= cur.rate * best_q;
		end
		if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			status_q  <= res_q;
			gidx_q    <= act_valid_q ? 4'(act_idx_q) : '0;
			first_q   <= (res_q == ST_GRANT) && (32'(act_idx_q) < FIRST_GROUP_SIZE);
			elapsed_q <= (res_q == ST_GRANT) ? best_q : '0;
			readyt_q  <= (res_q == ST_GRANT) ? 5'(ready_q) : '0;
			turnn_q   <= turn_q;
		end
	end

	assign out_valid           = out_valid_q;
	assign status              = status_q;
	assign granted_index       = gidx_q;
	assign granted_first_group = first_q;
	assign elapsed_units       = elapsed_q;
	assign ready_total         = readyt_q;
	assign turn_number         = turnn_q;

endmodule

// ===== hdl/crts_chk.sv =====
// Port checker of the credit ready time scheduler and its bind.
`timescale 1ns / 1ps
module crts_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [3:0]  granted_index,
	input logic        granted_first_group,
	input logic [15:0] elapsed_units,
	input logic [4:0]  ready_total,
	input logic [15:0] turn_number
);
	import crts_pkg::*;

	a_busy_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("Block took a second item straight after the first.");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(turn_number))
		else $error("Stalled result item changed.");

	a_grant_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_GRANT |-> ready_total != 5'd0)
		else $error("Grant made with no ready entry.");

	a_no_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_GRANT |-> elapsed_units == 16'd0 &&
		ready_total == 5'd0 && !granted_first_group)
		else $error("Grant fields set on a result item without a grant.");

endmodule

bind credit_ready_time_scheduler_unit crts_chk u_crts_chk (.*);

// ===== verif/credit_ready_time_scheduler_unit_tb.sv =====
// Self-checking testbench for the credit ready time scheduler with a built-in predictor.
`timescale 1ns / 1ps
module credit_ready_time_scheduler_unit_tb;
	import crts_pkg::*;

	localparam int FG = FIRST_GROUP_SIZE_DEF;
	localparam int TD = TABLE_DEPTH_DEF;
	localparam logic CFG_PLAYERS = 1'b0;
	localparam logic CFG_NPCS    = 1'b1;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  gidx;
		logic        first;
		logic [15:0] elapsed;
		logic [4:0]  ready;
		logic [15:0] turn;
	} sched_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [3:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] action = '0;
	logic [3:0] entry_index = '0;
	logic [15:0] credit_value = '0;
	logic [7:0] rate_value = '0;
	logic [15:0] ceiling_value = '0;
	logic alive_value = 1'b0;
	logic stunned_value = 1'b0;
	logic commit_flag = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] status;
	logic [3:0] granted_index;
	logic granted_first_group;
	logic [15:0] elapsed_units;
	logic [4:0] ready_total;
	logic [15:0] turn_number;

	credit_ready_time_scheduler_unit i_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state.
	logic [15:0] m_credit [TD];
	logic [7:0]  m_rate [TD];
	logic [15:0] m_ceiling [TD];
	logic        m_alive [TD];
	logic        m_stunned [TD];
	logic [3:0]  m_active;
	logic        m_active_valid;
	logic        m_closed;
	logic [15:0] m_turn;
	int unsigned m_players;
	int unsigned m_npcs;

	sched_result_t expected_results[$];
	int errors = 0;
	int grants = 0;
	int items_sent = 0;
	bit calm = 1'b0;

	function automatic bit is_active(int unsigned i);
		int unsigned pc;
		int unsigned nc;
		pc = (m_players > FG) ? FG : m_players;
		nc = (m_npcs > TD - FG) ? TD - FG : m_npcs;
		return (i < pc) || (i >= FG && i - FG < nc);
	endfunction

	function automatic bit refills(int unsigned i);
		return is_active(i) && m_alive[i] && !m_stunned[i] && m_rate[i] != 0;
	endfunction

	function automatic sched_result_t predict_schedule(action_t act, logic [3:0] idx,
			logic [15:0] cr, logic [7:0] rt, logic [15:0] ce, logic al, logic st, logic cm);
		sched_result_t r;
		bit found;
		bit sel;
		int unsigned best;
		int unsigned units;
		int unsigned v;
		r = '0;
		r.status = ST_WRITE;
		r.gidx = m_active_valid ? m_active : 4'd0;
		case (act)
			ACT_LOAD: begin
				m_credit[idx] = cr;
				m_rate[idx] = rt;
				m_ceiling[idx] = ce;
				m_alive[idx] = al;
				m_stunned[idx] = st;
			end
			ACT_CREDIT: begin
				m_credit[idx] = cr;
				if (cm) begin
					m_closed = 1'b1;
					m_turn = m_turn + 16'd1;
				end
			end
			ACT_SCHED: begin
				if (m_active_valid && !m_closed) begin
					r.status = ST_OPEN;
				end else begin
					found = 1'b0;
					best = 0;
					for (int i = 0; i < TD; i++) begin
						if (!refills(i)) continue;
						units = (m_credit[i] >= m_ceiling[i]) ? 0 :
							(m_ceiling[i] - m_credit[i] + m_rate[i] - 1) / m_rate[i];
						if (!found || units < best) best = units;
						found = 1'b1;
					end
					r.status = ST_NOELIG;
					if (found) begin
						if (best > 0) begin
							for (int i = 0; i < TD; i++) begin
								if (!refills(i)) continue;
								v = m_credit[i] + m_rate[i] * best;
								if (v > m_ceiling[i]) v = m_ceiling[i];
								m_credit[i] = v[15:0];
							end
						end
						sel = 1'b0;
						for (int i = 0; i < TD; i++) begin
							if (!is_active(i) || !m_alive[i] || m_stunned[i]) continue;
							if (m_credit[i] >= m_ceiling[i]) begin
								r.ready = r.ready + 5'd1;
								if (!sel) begin
									sel = 1'b1;
									m_active = i[3:0];
								end
							end
						end
						if (!sel) begin
							r.ready = '0;
						end else begin
							m_active_valid = 1'b1;
							m_closed = 1'b0;
							r.status = ST_GRANT;
							r.gidx = m_active;
							r.first = (m_active < FG);
							r.elapsed = best[15:0];
						end
					end
				end
			end
			default: ;
		endcase
		r.turn = m_turn;
		return r;
	endfunction

	task automatic send_item(action_t act, logic [3:0] idx, logic [15:0] cr, logic [7:0] rt,
			logic [15:0] ce, logic al, logic st, logic cm);
		while (!calm && $urandom_range(99) < 30) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		action <= act;
		entry_index <= idx;
		credit_value <= cr;
		rate_value <= rt;
		ceiling_value <= ce;
		alive_value <= al;
		stunned_value <= st;
		commit_flag <= cm;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		expected_results.push_back(predict_schedule(act, idx, cr, rt, ce, al, st, cm));
		items_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (450) @(negedge clk);
	endtask

	task automatic write_counts(logic [3:0] players, logic [3:0] npcs);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= CFG_PLAYERS;
		cfg_wdata <= players;
		@(negedge clk);
		cfg_index <= CFG_NPCS;
		cfg_wdata <= npcs;
		@(negedge clk);
		cfg_we <= 1'b0;
		m_players = players & 7;
		m_npcs = npcs;
	endtask

	task automatic random_load(logic [3:0] idx);
		send_item(ACT_LOAD, idx, 16'($urandom), ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom),
			($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(400)),
			$urandom_range(7) != 0, $urandom_range(5) == 0, 1'($urandom));
	endtask

	task automatic test_directed();
		write_counts(4'd4, 4'd12);
		send_item(ACT_SCHED, 0, 0, 0, 0, 0, 0, 0);
		send_item(ACT_LOAD, 0, 16'd0, 8'd1, 16'hFFFF, 1, 0, 0);
		send_item(ACT_LOAD, 15, 16'hFFFF, 8'hFF, 16'd10, 1, 0, 1);
		send_item(ACT_LOAD, 5, 16'd3, 8'd7, 16'd100, 1, 1, 1);
		send_item(ACT_LOAD, 6, 16'd0, 8'd0, 16'd5, 1, 0, 0);
		send_item(ACT_SCHED, 0, 0, 0, 0, 0, 0, 0);
		send_item(ACT_SCHED, 0, 0, 0, 0, 0, 0, 0);
		send_item(ACT_NONE, 4'hF, 16'hFFFF, 8'hFF, 16'hFFFF, 1, 1, 1);
		send_item(ACT_CREDIT, 15, 16'd0, 8'hFF, 16'hFFFF, 1, 1, 1);
		send_item(ACT_SCHED, 0, 0, 0, 0, 0, 0, 0);
		send_item(ACT_CREDIT, 3, 16'd0, 0, 0, 0, 0, 1);
		send_item(ACT_CREDIT, 0, 16'hFFFF, 0, 0, 0, 0, 0);
		send_item(ACT_SCHED, 0, 0, 0, 0, 0, 0, 0);
		write_counts(4'd7, 4'd15);
		send_item(ACT_CREDIT, 0, 16'd1, 0, 0, 0, 0, 1);
		send_item(ACT_SCHED, 0, 0, 0, 0, 0, 0, 0);
		write_counts(4'd0, 4'd0);
		send_item(ACT_CREDIT, 0, 16'd1, 0, 0, 0, 0, 1);
		send_item(ACT_SCHED, 0, 0, 0, 0, 0, 0, 0);
	endtask

	task automatic test_random_turns(int n_items);
		int done;
		done = 0;
		while (done < n_items) begin
			if ($urandom_range(9) == 0) random_load(4'($urandom));
			else if ($urandom_range(5) == 0)
				send_item(ACT_CREDIT, 4'($urandom), 16'($urandom), 8'($urandom),
					16'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
			else if ($urandom_range(15) == 0)
				send_item(ACT_NONE, 4'($urandom), 16'($urandom), 8'($urandom),
					16'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
			else begin
				send_item(ACT_SCHED, 4'($urandom), 16'($urandom), 8'($urandom),
					16'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
				send_item(ACT_CREDIT, 4'($urandom),
					$urandom_range(3) == 0 ? 16'($urandom) : 16'd0,
					0, 0, 0, 0, $urandom_range(4) != 0);
				done++;
			end
			done++;
		end
	endtask

	task automatic test_random_phases();
		for (int p = 0; p < 6; p++) begin
			write_counts(4'($urandom_range(7)), 4'($urandom_range(15)));
			for (int i = 0; i < TD; i++) random_load(4'(i));
			if (p == 2) calm = 1'b1;
			test_random_turns(115);
			calm = 1'b0;
			if (p == 3) drain();
		end
	endtask

	always @(negedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= 30);
	end

	always @(posedge clk) begin
		sched_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result, status %0d", status);
				errors++;
			end else begin
				e = expected_results.pop_front();
				if (e.status == ST_GRANT) grants++;
				if (status !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, status); errors++;
				end
				if (granted_index !== e.gidx) begin
					$error("granted_index: expected %0d, got %0d", e.gidx, granted_index);
					errors++;
				end
				if (granted_first_group !== e.first) begin
					$error("granted_first_group: expected %0d, got %0d", e.first,
						granted_first_group); errors++;
				end
				if (elapsed_units !== e.elapsed) begin
					$error("elapsed_units: expected %0d, got %0d", e.elapsed, elapsed_units);
					errors++;
				end
				if (ready_total !== e.ready) begin
					$error("ready_total: expected %0d, got %0d", e.ready, ready_total);
					errors++;
				end
				if (turn_number !== e.turn) begin
					$error("turn_number: expected %0d, got %0d", e.turn, turn_number);
					errors++;
				end
			end
		end
	end

	initial begin
		for (int i = 0; i < TD; i++) begin
			m_credit[i] = '0; m_rate[i] = '0; m_ceiling[i] = '0;
			m_alive[i] = 1'b0; m_stunned[i] = 1'b0;
		end
		m_active = '0; m_active_valid = 1'b0; m_closed = 1'b0; m_turn = '0;
		m_players = 0; m_npcs = 0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random_phases();
		drain();
		if (expected_results.size() != 0) begin
			$error("%0d results never arrived", expected_results.size());
			errors++;
		end
		$display("Sent %0d items over several count settings; %0d grants were checked.",
			items_sent, grants);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
